[hdl/sbfc_pkg.sv]
// sbfc_pkg: shared types, codes and helper functions for the six-byte frame checker
// no dependencies; used by sbfc_cfg_if, sbfc_frame_eval and the top level
`timescale 1ns / 1ps
`default_nettype none

package sbfc_pkg;

  localparam int FRAME_LEN   = 6;
  localparam int STORE_DEPTH = FRAME_LEN - 1;
  localparam int POS_W       = 3;
  localparam int CFG_IDX_W   = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST = 8'd3;

  // reset values of the registers
  localparam logic [7:0] HEADER_RST  = 8'hFF;
  localparam logic [7:0] TRAILER_RST = 8'h0A;
  localparam logic [7:0] ALARM_RST   = 8'hFF;
  localparam logic [7:0] REQUEST_RST = 8'hAA;

  // frame status codes
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_FRAMING  = 2'd2;

  // frame kind codes
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_ALARM   = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] trailer_value;
    logic [7:0] alarm_pattern;
    logic [7:0] request_pattern;
  } cfg_t;

  typedef struct packed {
    logic [1:0] frame_status;
    logic       resend_request;
    logic [1:0] frame_kind;
    logic       latch_en;
  } eval_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[hdl/sbfc_in_if.sv]
// sbfc_in_if: received byte channel (valid/ready)
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sbfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hdl/sbfc_out_if.sv]
// sbfc_out_if: frame result channel (valid/ready)
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sbfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic       resend_request;
  logic [1:0] frame_kind;
  logic [7:0] remote_exposure;
  logic [7:0] remote_minutes;
  logic [7:0] remote_voc;

  modport source (output valid, output frame_status, output resend_request,
                  output frame_kind, output remote_exposure, output remote_minutes,
                  output remote_voc, input ready);
  modport sink (input valid, input frame_status, input resend_request,
                input frame_kind, input remote_exposure, input remote_minutes,
                input remote_voc, output ready);
endinterface

`default_nettype wire

[hdl/sbfc_cfg_if.sv]
// sbfc_cfg_if: register write channel (valid/ready, index and data)
// depends on sbfc_pkg for the index width
`timescale 1ns / 1ps
`default_nettype none

interface sbfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sbfc_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/sbfc_frame_eval.sv]
// sbfc_frame_eval: combinational check of a complete frame (status, kind, latch enable)
// depends on sbfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbfc_frame_eval (
  input  wire logic [7:0]      header_byte,
  input  wire logic [7:0]      pay0,
  input  wire logic [7:0]      pay1,
  input  wire logic [7:0]      pay2,
  input  wire logic [7:0]      checksum,
  input  wire logic [7:0]      trailer_byte,
  input  wire sbfc_pkg::cfg_t  cfg,
  output sbfc_pkg::eval_t      res
);

  logic [4:0] count;
  logic [7:0] all_and;

  always_comb begin
    count = {1'b0, sbfc_pkg::ones8(pay0)} + {1'b0, sbfc_pkg::ones8(pay1)}
          + {1'b0, sbfc_pkg::ones8(pay2)};
    all_and = pay0 & pay1 & pay2;

    // checksum error wins over framing error
    priority if (checksum != {3'd0, count}) begin
      res.frame_status = sbfc_pkg::ST_CHECKSUM;
    end else if (header_byte != cfg.header_value || trailer_byte != cfg.trailer_value) begin
      res.frame_status = sbfc_pkg::ST_FRAMING;
    end else begin
      res.frame_status = sbfc_pkg::ST_VALID;
    end
    res.resend_request = (res.frame_status != sbfc_pkg::ST_VALID);

    res.latch_en = 1'b0;
    priority if (all_and == cfg.alarm_pattern) begin
      res.frame_kind = sbfc_pkg::KIND_ALARM;
    end else if (all_and == cfg.request_pattern) begin
      res.frame_kind = sbfc_pkg::KIND_REQUEST;
    end else begin
      res.frame_kind = sbfc_pkg::KIND_DATA;
      res.latch_en   = 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/six_byte_frame_checker_unit.sv]
// six_byte_frame_checker_unit: groups received bytes into six-byte frames and checks them
// depends on sbfc_pkg, the three channel interfaces and sbfc_frame_eval
//
// usage:
//   in_ch  - one received byte per word; frames are header, three payload bytes,
//            checksum (count of 1 bits in the payload) and trailer
//   out_ch - one result word per frame: status, resend flag, kind and the latched
//            remote values as they stand after that frame
//   cfg_ch - register writes (header, trailer, alarm pattern, request pattern);
//            ready is always high, unknown indexes are dropped
// timing:
//   a byte is taken in each cycle with in_ch.valid and in_ch.ready high; the sixth
//   byte of a frame is checked when taken; its result shows on out_ch in the next cycle
//   throughput is one byte per cycle as long as out_ch takes each result word
// stall:
//   while a result waits and out_ch.ready is low, in_ch.ready drops; it stays
//   high in the cycle the waiting result is taken
// reset:
//   rst_n (synchronous, active low) restarts framing at the header byte, clears
//   the latched remote values, empties the result register and reloads the
//   register defaults
`timescale 1ns / 1ps
`default_nettype none

module six_byte_frame_checker_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  sbfc_in_if.sink   in_ch,
  sbfc_out_if.source out_ch,
  sbfc_cfg_if.sink  cfg_ch
);

  sbfc_pkg::cfg_t cfg_r;
  logic [sbfc_pkg::POS_W-1:0] pos_r;
  logic [7:0] store_r [sbfc_pkg::STORE_DEPTH];
  logic [7:0] exposure_r, minutes_r, voc_r;
  logic [7:0] exposure_nxt, minutes_nxt, voc_nxt;

  logic       out_valid_r;
  logic [1:0] status_r;
  logic       resend_r;
  logic [1:0] kind_r;

  logic in_take;
  logic last_byte;
  sbfc_pkg::eval_t eval;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_take      = in_ch.valid && in_ch.ready;
  // any position past the stored bytes closes the frame
  assign last_byte    = (pos_r >= sbfc_pkg::POS_W'(sbfc_pkg::STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value    <= sbfc_pkg::HEADER_RST;
      cfg_r.trailer_value   <= sbfc_pkg::TRAILER_RST;
      cfg_r.alarm_pattern   <= sbfc_pkg::ALARM_RST;
      cfg_r.request_pattern <= sbfc_pkg::REQUEST_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        sbfc_pkg::REG_HEADER:  cfg_r.header_value    <= cfg_ch.data;
        sbfc_pkg::REG_TRAILER: cfg_r.trailer_value   <= cfg_ch.data;
        sbfc_pkg::REG_ALARM:   cfg_r.alarm_pattern   <= cfg_ch.data;
        sbfc_pkg::REG_REQUEST: cfg_r.request_pattern <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  sbfc_frame_eval u_eval (
    .header_byte  (store_r[0]),
    .pay0         (store_r[1]),
    .pay1         (store_r[2]),
    .pay2         (store_r[3]),
    .checksum     (store_r[4]),
    .trailer_byte (in_ch.rx_byte),
    .cfg          (cfg_r),
    .res          (eval)
  );

  always_comb begin
    exposure_nxt = exposure_r;
    minutes_nxt  = minutes_r;
    voc_nxt      = voc_r;
    if (eval.latch_en) begin
      exposure_nxt = store_r[1];
      minutes_nxt  = store_r[2];
      voc_nxt      = store_r[3];
    end
  end

  // byte position, latched values and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      exposure_r  <= '0;
      minutes_r   <= '0;
      voc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take && last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_take) begin
        if (last_byte) begin
          pos_r       <= '0;
          exposure_r  <= exposure_nxt;
          minutes_r   <= minutes_nxt;
          voc_r       <= voc_nxt;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  // frame store and result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (last_byte) begin
        status_r <= eval.frame_status;
        resend_r <= eval.resend_request;
        kind_r   <= eval.frame_kind;
      end else begin
        store_r[pos_r] <= in_ch.rx_byte;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.frame_status    = status_r;
  assign out_ch.resend_request  = resend_r;
  assign out_ch.frame_kind      = kind_r;
  assign out_ch.remote_exposure = exposure_r;
  assign out_ch.remote_minutes  = minutes_r;
  assign out_ch.remote_voc      = voc_r;

endmodule

`default_nettype wire

[sim/tb_six_byte_frame_checker_unit.sv]
// tb_six_byte_frame_checker_unit: self-checking bench for the six-byte frame checker
// depends on sbfc_pkg, sbfc_in_if, sbfc_out_if, sbfc_cfg_if and six_byte_frame_checker_unit
// drives byte frames and register writes, predicts every result word and compares it
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0] status;
  logic       resend;
  logic [1:0] kind;
  logic [7:0] exposure;
  logic [7:0] minutes;
  logic [7:0] voc;
} frame_word_t;

class frame_scoreboard;
  logic [7:0]  header_val;
  logic [7:0]  trailer_val;
  logic [7:0]  alarm_pat;
  logic [7:0]  request_pat;
  logic [2:0]  byte_pos;
  logic [7:0]  frame_bytes [5];
  logic [7:0]  exposure_q;
  logic [7:0]  minutes_q;
  logic [7:0]  voc_q;
  frame_word_t due_frames [$];
  int          errors;

  function new();
    header_val  = sbfc_pkg::HEADER_RST;
    trailer_val = sbfc_pkg::TRAILER_RST;
    alarm_pat   = sbfc_pkg::ALARM_RST;
    request_pat = sbfc_pkg::REQUEST_RST;
    byte_pos    = 3'd0;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'd0;
    exposure_q  = 8'd0;
    minutes_q   = 8'd0;
    voc_q       = 8'd0;
    errors      = 0;
  endfunction

  function int count_ones(input logic [7:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) n += v[i];
    return n;
  endfunction

  function void write_reg(input logic [sbfc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    case (idx)
      sbfc_pkg::REG_HEADER:  header_val = val;
      sbfc_pkg::REG_TRAILER: trailer_val = val;
      sbfc_pkg::REG_ALARM:   alarm_pat = val;
      sbfc_pkg::REG_REQUEST: request_pat = val;
      default: ;
    endcase
  endfunction

  function void note_rx_byte(input logic [7:0] b);
    frame_word_t w;
    int          ones;
    logic [7:0]  all_and;
    if (byte_pos < 3'd5) begin
      frame_bytes[byte_pos] = b;
      byte_pos = byte_pos + 3'd1;
      return;
    end
    byte_pos = 3'd0;
    ones = count_ones(frame_bytes[1]) + count_ones(frame_bytes[2]) + count_ones(frame_bytes[3]);
    // checksum wins over framing
    if (int'(frame_bytes[4]) != ones) begin
      w.status = sbfc_pkg::ST_CHECKSUM;
    end else if (frame_bytes[0] != header_val || b != trailer_val) begin
      w.status = sbfc_pkg::ST_FRAMING;
    end else begin
      w.status = sbfc_pkg::ST_VALID;
    end
    w.resend = (w.status != sbfc_pkg::ST_VALID);
    all_and = frame_bytes[1] & frame_bytes[2] & frame_bytes[3];
    if (all_and == alarm_pat) begin
      w.kind = sbfc_pkg::KIND_ALARM;
    end else if (all_and == request_pat) begin
      w.kind = sbfc_pkg::KIND_REQUEST;
    end else begin
      // data frames latch whatever the status
      w.kind = sbfc_pkg::KIND_DATA;
      exposure_q = frame_bytes[1];
      minutes_q = frame_bytes[2];
      voc_q = frame_bytes[3];
    end
    w.exposure = exposure_q;
    w.minutes = minutes_q;
    w.voc = voc_q;
    due_frames.push_back(w);
  endfunction

  function void report(input string field, input int exp_v, input int act_v);
    errors++;
    // report the first 200 mismatches
    if (errors <= 200) $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
  endfunction

  function void check_frame_word(input frame_word_t got);
    frame_word_t exp_w;
    if (due_frames.size() == 0) begin
      errors++;
      if (errors <= 200) $error("result word with no frame pending");
      return;
    end
    exp_w = due_frames.pop_front();
    if (got.status !== exp_w.status) report("frame_status", exp_w.status, got.status);
    if (got.resend !== exp_w.resend) report("resend_request", exp_w.resend, got.resend);
    if (got.kind !== exp_w.kind) report("frame_kind", exp_w.kind, got.kind);
    if (got.exposure !== exp_w.exposure) report("remote_exposure", exp_w.exposure, got.exposure);
    if (got.minutes !== exp_w.minutes) report("remote_minutes", exp_w.minutes, got.minutes);
    if (got.voc !== exp_w.voc) report("remote_voc", exp_w.voc, got.voc);
  endfunction
endclass

module tb_six_byte_frame_checker_unit;

  localparam int NUM_PHASES       = 8;
  localparam int FRAMES_PER_PHASE = 36;
  localparam int HOLD_CYCLES      = 300;

  logic clk = 1'b0;
  logic rst_n;

  sbfc_in_if  in_ch ();
  sbfc_out_if out_ch ();
  sbfc_cfg_if cfg_ch ();

  frame_scoreboard sb;

  six_byte_frame_checker_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len(input bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // payload whose AND is the alarm pattern, the request pattern, or just random
  function automatic logic [23:0] payload_for(input int sel);
    logic [7:0]  pat;
    logic [23:0] p;
    int          rot;
    if (sel == 2) return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255))};
    pat = (sel == 0) ? sb.alarm_pat : sb.request_pat;
    p = {pat, pat | 8'($urandom_range(0, 255)), pat | 8'($urandom_range(0, 255))};
    rot = $urandom_range(0, 2);
    repeat (rot) p = {p[15:0], p[23:16]};
    return p;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit no_idle);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_rx_byte(b);
    gap = idle_len(no_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_bytes6(input logic [47:0] f);
    for (int i = 5; i >= 0; i--) send_byte(f[i*8 +: 8], 1'b0);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.due_frames.size() != 0);
  endtask

  task automatic program_regs(input logic [7:0] hdr, input logic [7:0] trl,
                              input logic [7:0] alm, input logic [7:0] req,
                              input logic [sbfc_pkg::CFG_IDX_W-1:0] stray_idx);
    logic [sbfc_pkg::CFG_IDX_W-1:0] idx [5];
    logic [7:0]                     val [5];
    idx = '{sbfc_pkg::REG_HEADER, sbfc_pkg::REG_TRAILER, sbfc_pkg::REG_ALARM,
            sbfc_pkg::REG_REQUEST, stray_idx};
    val = '{hdr, trl, alm, req, 8'($urandom_range(0, 255))};
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame(input bit no_idle);
    logic [23:0] pay;
    logic [7:0]  hdr;
    logic [7:0]  sum;
    logic [7:0]  trl;
    int          flaw;
    // slip framing now and then, realign later with filler bytes
    if ($urandom_range(0, 24) == 0) begin
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), no_idle);
    end
    if (sb.byte_pos != 3'd0 && $urandom_range(0, 1) == 1) begin
      while (sb.byte_pos != 3'd0) send_byte(8'($urandom_range(0, 255)), no_idle);
    end
    pay = payload_for($urandom_range(0, 2));
    hdr = sb.header_val;
    trl = sb.trailer_val;
    sum = 8'(sb.count_ones(pay[23:16]) + sb.count_ones(pay[15:8]) + sb.count_ones(pay[7:0]));
    flaw = $urandom_range(0, 99);
    if (flaw >= 95) begin
      {hdr, pay, sum, trl} = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    end else if (flaw >= 90) begin
      sum = 8'($urandom_range(0, 255));
    end else if (flaw >= 82) begin
      sum = sum ^ (8'd1 << $urandom_range(0, 7));
    end else if (flaw >= 76) begin
      trl = trl ^ 8'($urandom_range(1, 255));
    end else if (flaw >= 70) begin
      hdr = hdr ^ 8'($urandom_range(1, 255));
    end
    send_byte(hdr, no_idle);
    send_byte(pay[23:16], no_idle);
    send_byte(pay[15:8], no_idle);
    send_byte(pay[7:0], no_idle);
    send_byte(sum, no_idle);
    send_byte(trl, no_idle);
  endtask

  // result side: random stalls, stretches with none, and long hold-offs
  initial begin : result_sink
    frame_word_t got;
    int          taken;
    int          calm_left;
    int          gap;
    taken = 0;
    calm_left = 0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.frame_status, out_ch.resend_request, out_ch.frame_kind,
              out_ch.remote_exposure, out_ch.remote_minutes, out_ch.remote_voc};
      sb.check_frame_word(got);
      taken++;
      if (calm_left == 0 && $urandom_range(0, 15) == 0) calm_left = 24;
      if (taken == 20 || taken == 140) begin
        gap = HOLD_CYCLES;
      end else if (calm_left > 0) begin
        calm_left--;
        gap = 0;
      end else begin
        gap = idle_len(1'b0);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : byte_source
    logic [7:0] pat;
    bit         no_idle;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset register values
    send_bytes6({sbfc_pkg::HEADER_RST, 8'h00, 8'h00, 8'h00, 8'h00, sbfc_pkg::TRAILER_RST});
    // all payload bits set: largest bit count, alarm frame
    send_bytes6({sbfc_pkg::HEADER_RST, 8'hFF, 8'hFF, 8'hFF, 8'd24, sbfc_pkg::TRAILER_RST});
    // checksum off only above bit 3, header and trailer bad too: checksum status wins
    send_bytes6({8'h00, 8'hAA, 8'hAB, 8'hBA, 8'h1E, 8'hFF});
    // bad trailer on a data frame: payload still latched
    send_bytes6({sbfc_pkg::HEADER_RST, 8'h81, 8'h42, 8'h24, 8'h06, 8'h0B});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        pat = 8'($urandom_range(0, 255));
        case (ph)
          1: program_regs(8'h00, 8'h00, 8'h00, 8'h00, sbfc_pkg::REG_REQUEST + 8'd1);
          2: program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
          4: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pat, pat,
                          8'($urandom_range(4, 255)));
          default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(4, 255)));
        endcase
      end
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        if (ph == 3 && f == FRAMES_PER_PHASE / 2) wait_drained();
        no_idle = ($urandom_range(0, 4) == 0);
        send_frame(no_idle);
      end
      // finish any partial frame before the registers change
      while (sb.byte_pos != 3'd0) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[six_byte_frame_checker_unit.f]
hdl/sbfc_pkg.sv
hdl/sbfc_in_if.sv
hdl/sbfc_out_if.sv
hdl/sbfc_cfg_if.sv
hdl/sbfc_frame_eval.sv
hdl/six_byte_frame_checker_unit.sv
sim/tb_six_byte_frame_checker_unit.sv
